// ----- hw/rtl/efpa_pkg.sv -----
// Shared types and constants for the encoder frame parser and accumulator.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps
`default_nettype none

package efpa_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam int          MSG_LEN    = 5;
    localparam logic [2:0]  LAST_IDX   = 3'(MSG_LEN - 1);
    localparam logic [2:0]  IDLE_IDX   = 3'd7;
    localparam logic [15:0] COUNT_BIAS = 16'h8000;

    // Accumulator width; the position outputs carry its low 32 bits.
    localparam int ACC_BITS = 32;
    localparam int POS_W    = 32;
    localparam int DELTA_W  = 15;

    // Frame queue between parser and accumulator
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One parsed frame: checksum verdict and the two raw big-endian words
    typedef struct packed {
        logic        ok;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_frame;

endpackage

`default_nettype wire

// ----- hw/rtl/efpa_front.sv -----
// Byte parser: sync detection, frame slot tracking and checksum check.
// Pushes one t_frame per completed frame. Depends on efpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efpa_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output efpa_pkg::t_frame     o_frame
);
    import efpa_pkg::*;

    logic       r_prev_sync;
    logic [2:0] r_idx;
    logic [7:0] r_bytes [0:3];

    logic       w_take;
    logic       w_is_sync;
    logic       w_restart;
    logic       w_in_frame;
    logic [7:0] w_sum;

    assign o_in_stall = i_q_full;
    assign w_take     = i_in_valid && !i_q_full;
    assign w_is_sync  = (i_rx_byte == SYNC_BYTE);
    assign w_restart  = w_is_sync && r_prev_sync;
    assign w_in_frame = (r_idx < 3'(MSG_LEN));

    // last byte of the frame is the checksum, compared straight off the input
    assign w_sum = r_bytes[0] + r_bytes[1] + r_bytes[2] + r_bytes[3];

    assign o_push         = w_take && !w_restart && (r_idx == LAST_IDX);
    assign o_frame.ok     = (w_sum == i_rx_byte);
    assign o_frame.word_a = {r_bytes[0], r_bytes[1]};
    assign o_frame.word_b = {r_bytes[2], r_bytes[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sync <= 1'b0;
            r_idx       <= IDLE_IDX;
        end else if (w_take) begin
            if (w_restart) begin
                r_idx <= 3'd0;
            end else if (!w_in_frame) begin
                r_prev_sync <= w_is_sync;
            end else if (r_idx == LAST_IDX) begin
                // frame done: a trailing 0xFF does not count toward the next sync
                r_prev_sync <= 1'b0;
                r_idx       <= IDLE_IDX;
            end else begin
                r_prev_sync <= w_is_sync;
                r_idx       <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !w_restart && w_in_frame && (r_idx != LAST_IDX)) begin
            r_bytes[r_idx[1:0]] <= i_rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_push_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_idx == IDLE_IDX) && !r_prev_sync)
        else $error("parser not idle after frame end");
    a_restart_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_restart |=> (r_idx == 3'd0) && r_prev_sync)
        else $error("sync pair did not restart frame");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_push)
        else $error("frame pushed into full queue");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/efpa_queue.sv -----
// Small frame queue that decouples the parser from the accumulator.
// Depth from QUEUE_DEPTH. Depends on efpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efpa_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire efpa_pkg::t_frame i_frame,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output efpa_pkg::t_frame      o_frame
);
    import efpa_pkg::*;

    t_frame              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rptr];

    function automatic logic [QPTR_W-1:0] f_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] v;
        v = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= f_inc(r_wptr);
            if (i_pop)  r_rptr <= f_inc(r_rptr);
            if (i_push && !i_pop)      r_count <= r_count + QCNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_frame;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/efpa_back.sv -----
// Accumulator: turns words into counts, wrapped deltas and tick totals,
// and holds the result register. Depends on efpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efpa_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire efpa_pkg::t_frame     i_frame,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_checksum_ok,
    output logic signed [14:0]        o_delta_a,
    output logic signed [14:0]        o_delta_b,
    output logic signed [31:0]        o_position_a,
    output logic signed [31:0]        o_position_b
);
    import efpa_pkg::*;

    localparam int EXT_W = (ACC_BITS > POS_W) ? ACC_BITS : POS_W;

    logic                       r_out_valid;
    logic                       r_awaiting;
    logic [15:0]                r_last_a;
    logic [15:0]                r_last_b;
    logic [ACC_BITS-1:0]        r_total_a;
    logic [ACC_BITS-1:0]        r_total_b;
    logic                       r_ok;
    logic signed [DELTA_W-1:0]  r_delta_a;
    logic signed [DELTA_W-1:0]  r_delta_b;
    logic [POS_W-1:0]           r_pos_a;
    logic [POS_W-1:0]           r_pos_b;

    logic [15:0]                w_cnt_a;
    logic [15:0]                w_cnt_b;
    logic [15:0]                w_diff_a;
    logic [15:0]                w_diff_b;
    logic                       w_use;
    logic signed [DELTA_W-1:0]  w_delta_a;
    logic signed [DELTA_W-1:0]  w_delta_b;
    logic [ACC_BITS-1:0]        w_total_a;
    logic [ACC_BITS-1:0]        w_total_b;
    logic [EXT_W-1:0]           w_ext_a;
    logic [EXT_W-1:0]           w_ext_b;

    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);

    assign w_cnt_a  = COUNT_BIAS - i_frame.word_a;
    assign w_cnt_b  = COUNT_BIAS - i_frame.word_b;
    assign w_diff_a = w_cnt_a - r_last_a;
    assign w_diff_b = w_cnt_b - r_last_b;

    // deltas are zero on a refused frame and on the first good one
    assign w_use     = i_frame.ok && !r_awaiting;
    assign w_delta_a = w_use ? $signed(w_diff_a[DELTA_W-1:0]) : '0;
    assign w_delta_b = w_use ? $signed(w_diff_b[DELTA_W-1:0]) : '0;

    assign w_total_a = r_total_a + ACC_BITS'(w_delta_a);
    assign w_total_b = r_total_b + ACC_BITS'(w_delta_b);
    assign w_ext_a   = EXT_W'(w_total_a);
    assign w_ext_b   = EXT_W'(w_total_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_awaiting  <= 1'b1;
            r_last_a    <= '0;
            r_last_b    <= '0;
            r_total_a   <= '0;
            r_total_b   <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_total_a   <= w_total_a;
                r_total_b   <= w_total_b;
                if (i_frame.ok) begin
                    r_last_a   <= w_cnt_a;
                    r_last_b   <= w_cnt_b;
                    r_awaiting <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok      <= i_frame.ok;
            r_delta_a <= w_delta_a;
            r_delta_b <= w_delta_b;
            r_pos_a   <= w_ext_a[POS_W-1:0];
            r_pos_b   <= w_ext_b[POS_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_checksum_ok = r_ok;
    assign o_delta_a     = r_delta_a;
    assign o_delta_b     = r_delta_b;
    assign o_position_a  = $signed(r_pos_a);
    assign o_position_b  = $signed(r_pos_b);

`ifndef SYNTHESIS
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> (r_delta_a == '0) && (r_delta_b == '0))
        else $error("refused frame carries nonzero delta");
    a_refused_keeps_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_frame.ok |=> $stable(r_total_a) && $stable(r_total_b))
        else $error("refused frame changed totals");
    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_frame.ok |=> !r_awaiting)
        else $error("first-frame flag not cleared");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_frame_parser_accumulator_top.sv -----
// Top level of the encoder frame parser and tick accumulator.
// Instantiates efpa_front, efpa_queue and efpa_back; depends on efpa_pkg.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+--------------------------
//   in      | i_rx_byte                              | i_in_valid / o_in_stall
//   out     | o_checksum_ok, o_delta_a/b, o_position_a/b | o_out_valid / i_out_stall
//
// One byte can be taken every cycle. A completed frame goes from the parser
// into the frame queue and then into the output register, which drives the
// outputs. Input stalls only when the two-entry frame queue is full, which
// needs the output side stalled. Reset (i_rst_n low, synchronous) idles the
// parser, empties the queue and clears the totals.
`timescale 1ns / 1ps
`default_nettype none

module encoder_frame_parser_accumulator_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_checksum_ok,
    output logic signed [14:0]      o_delta_a,
    output logic signed [14:0]      o_delta_b,
    output logic signed [31:0]      o_position_a,
    output logic signed [31:0]      o_position_b
);
    import efpa_pkg::*;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_frame w_push_frame;
    t_frame w_head_frame;

    efpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_frame    (w_push_frame)
    );

    efpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_frame (w_head_frame)
    );

    efpa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_frame       (w_head_frame),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_checksum_ok (o_checksum_ok),
        .o_delta_a     (o_delta_a),
        .o_delta_b     (o_delta_b),
        .o_position_a  (o_position_a),
        .o_position_b  (o_position_b)
    );

endmodule

`default_nettype wire

// ----- bench/tb_encoder_frame_parser_accumulator_top.sv -----
// Self-checking bench for encoder_frame_parser_accumulator_top: byte stream in, frame verdicts out.
// Holds its own model of the parser and tick totals in a small class; depends on efpa_pkg.
`timescale 1ns / 1ps

module tb_encoder_frame_parser_accumulator_top;

    import efpa_pkg::*;

    typedef struct {
        logic               ok;
        logic signed [14:0] delta_a;
        logic signed [14:0] delta_b;
        logic signed [31:0] pos_a;
        logic signed [31:0] pos_b;
    } frame_verdict_t;

    class encoder_tracker;
        bit                sync_seen;
        logic [2:0]        slot_idx;
        logic [7:0]        slot_byte [MSG_LEN];
        logic [15:0]       last_cnt [2];
        bit                prime;
        logic [63:0]       tick_sum [2];
        frame_verdict_t    pending_frames [$];
        int                errors;
        int                good_frames;
        int                refused_frames;

        function new();
            sync_seen = 1'b0;
            slot_idx  = IDLE_IDX;
            prime     = 1'b1;
            for (int k = 0; k < 2; k++) begin
                last_cnt[k] = '0;
                tick_sum[k] = '0;
            end
            errors = 0;
            good_frames = 0;
            refused_frames = 0;
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Feed one transferred byte; queues a verdict when it closes a frame.
        function void take_byte(logic [7:0] b);
            bit             is_sync;
            logic [7:0]     sum;
            logic [15:0]    word;
            logic [15:0]    cnt;
            logic [15:0]    diff;
            logic [14:0]    d [2];
            logic [63:0]    mask;
            frame_verdict_t v;

            is_sync = (b == SYNC_BYTE);
            if (is_sync && sync_seen) begin
                slot_idx = 3'd0;
                return;
            end
            sync_seen = is_sync;
            if (slot_idx >= MSG_LEN)
                return;
            slot_byte[slot_idx] = b;
            slot_idx = slot_idx + 3'd1;
            if (slot_idx < MSG_LEN)
                return;

            // frame closed: a trailing 0xFF must not pair with the next byte
            sync_seen = 1'b0;
            slot_idx  = IDLE_IDX;
            sum = '0;
            for (int k = 0; k < MSG_LEN - 1; k++)
                sum = sum + slot_byte[k];
            v.ok = (sum == slot_byte[MSG_LEN - 1]);
            d[0] = '0;
            d[1] = '0;
            mask = (ACC_BITS >= 64) ? '1 : ((64'd1 << ACC_BITS) - 64'd1);
            if (v.ok) begin
                for (int e = 0; e < 2; e++) begin
                    word = {slot_byte[2 * e], slot_byte[2 * e + 1]};
                    cnt  = COUNT_BIAS - word;
                    if (prime)
                        last_cnt[e] = cnt;
                    diff = cnt - last_cnt[e];
                    d[e] = diff[14:0];
                    last_cnt[e] = cnt;
                    tick_sum[e] = (tick_sum[e] + {{49{d[e][14]}}, d[e]}) & mask;
                end
                prime = 1'b0;
            end
            v.delta_a = d[0];
            v.delta_b = d[1];
            v.pos_a   = tick_sum[0][31:0];
            v.pos_b   = tick_sum[1][31:0];
            pending_frames.push_back(v);
        endfunction

        task check_result(frame_verdict_t got);
            frame_verdict_t want;
            if (pending_frames.size() == 0) begin
                flag_mismatch("result with nothing expected");
                return;
            end
            want = pending_frames.pop_front();
            if (want.ok) good_frames++;
            else refused_frames++;
            if (got.ok !== want.ok)
                flag_mismatch($sformatf("checksum_ok got %b want %b", got.ok, want.ok));
            if (got.delta_a !== want.delta_a)
                flag_mismatch($sformatf("delta_a got %0d want %0d", got.delta_a, want.delta_a));
            if (got.delta_b !== want.delta_b)
                flag_mismatch($sformatf("delta_b got %0d want %0d", got.delta_b, want.delta_b));
            if (got.pos_a !== want.pos_a)
                flag_mismatch($sformatf("position_a got %0d want %0d", got.pos_a, want.pos_a));
            if (got.pos_b !== want.pos_b)
                flag_mismatch($sformatf("position_b got %0d want %0d", got.pos_b, want.pos_b));
        endtask

        function int waiting();
            return pending_frames.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_checksum_ok;
    logic signed [14:0] o_delta_a;
    logic signed [14:0] o_delta_b;
    logic signed [31:0] o_position_a;
    logic signed [31:0] o_position_b;

    encoder_tracker tracker;
    int             frame_bytes_sent = 0;
    int             gap_odds = 0;     // 1 in N chance of an input gap, 0 = none
    int             stall_odds = 0;   // 1 in N chance of an output stall burst, 0 = none
    int             stall_hold = 0;
    logic [15:0]    word_a = 16'h8000;
    logic [15:0]    word_b = 16'h8000;

    encoder_frame_parser_accumulator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_checksum_ok (o_checksum_ok),
        .o_delta_a     (o_delta_a),
        .o_delta_b     (o_delta_b),
        .o_position_a  (o_position_a),
        .o_position_b  (o_position_b)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold  <= stall_hold - 1;
            i_out_stall <= 1'b1;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_hold  <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor both channels; inputs are noted first so a same-edge result still finds its entry
    always @(posedge i_clk) begin
        frame_verdict_t got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tracker.take_byte(i_rx_byte);
            if (o_out_valid && !i_out_stall) begin
                got.ok      = o_checksum_ok;
                got.delta_a = o_delta_a;
                got.delta_b = o_delta_b;
                got.pos_a   = o_position_a;
                got.pos_b   = o_position_b;
                tracker.check_result(got);
            end
        end
    end

    task automatic push_byte(logic [7:0] b);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_frame(logic [15:0] wa, logic [15:0] wb, bit corrupt);
        logic [7:0] cks;
        cks = wa[15:8] + wa[7:0] + wb[15:8] + wb[7:0];
        if (corrupt)
            cks = cks ^ 8'($urandom_range(1, 255));
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(wa[15:8]);
        push_byte(wa[7:0]);
        push_byte(wb[15:8]);
        push_byte(wb[7:0]);
        push_byte(cks);
        frame_bytes_sent += 7;
    endtask

    function automatic logic [15:0] next_word(logic [15:0] w);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return w + 16'($urandom_range(0, 600)) - 16'd300;
    endfunction

    initial begin
        int kind;
        int n;
        int phase;
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first good frame ending in 0xFF, lone 0xFF after frame end,
        // refused frame, restart mid-frame, delta extremes
        gap_odds   = 4;
        stall_odds = 4;
        send_frame(16'h8000, 16'h7F00, 1'b0);
        push_byte(SYNC_BYTE);
        push_byte(8'h01);
        send_frame(16'h0000, 16'hFFFE, 1'b1);
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(8'h12);
        push_byte(8'h34);
        send_frame(16'h4001, 16'h3F00, 1'b0);
        word_a = 16'h4001;
        word_b = 16'h3F00;

        while (frame_bytes_sent < 1700) begin
            phase = frame_bytes_sent * 4 / 1700;
            case (phase)
                0: begin gap_odds = 3; stall_odds = 3; end
                1: begin gap_odds = 0; stall_odds = 2; end
                2: begin gap_odds = 2; stall_odds = 0; end
                default: begin gap_odds = 0; stall_odds = 0; end
            endcase
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                word_a = next_word(word_a);
                word_b = next_word(word_b);
                send_frame(word_a, word_b, 1'b0);
            end else if (kind < 80) begin
                send_frame(16'($urandom), 16'($urandom), 1'b1);
            end else if (kind < 90) begin
                // truncated frame: a sync pair and at most four more bytes before the next item
                push_byte(SYNC_BYTE);
                push_byte(SYNC_BYTE);
                n = $urandom_range(1, 4);
                repeat (n) push_byte(8'($urandom));
                frame_bytes_sent += 2 + n;
            end else if (kind < 94) begin
                push_byte(SYNC_BYTE);
                frame_bytes_sent += 1;
            end else begin
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.waiting() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d frame-stream bytes: %0d good and %0d refused frames checked.",
                 frame_bytes_sent, tracker.good_frames, tracker.refused_frames);
        $display("Mismatches: %0d", tracker.errors);
        if (tracker.errors == 0) begin
            $display("[encoder_frame_parser_accumulator_top] OK");
        end else begin
            $display("[encoder_frame_parser_accumulator_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", tracker.waiting());
        $display("[encoder_frame_parser_accumulator_top] ERROR");
        $finish;
    end

endmodule
